@@ hdl/cske_pkg.sv @@
// Shared types and constants for the chromosome sort key extractor.
package cske_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 16;

    localparam int unsigned KEY_W       = 31;
    localparam int unsigned POS_W       = 31;
    localparam int unsigned FIELD_LEN_W = 16;
    localparam int unsigned HASH15_W    = 15;
    localparam int unsigned NAME_HASH_W = 30;
    localparam int unsigned DIGIT_W     = 5;
    localparam int unsigned REL_W       = 4;
    localparam int unsigned SFX_CNT_W   = 4;

    localparam logic [FIELD_LEN_W-1:0] FIELD_LEN_MAX  = 16'hFFFF;
    localparam logic [POS_W-1:0]       POS_MAX        = 31'h7FFF_FFFF;
    localparam logic [DIGIT_W-1:0]     DIGIT_SAT      = 5'd31;
    localparam logic [DIGIT_W-1:0]     NUMBER_MAX     = 5'd22;
    localparam logic [REL_W-1:0]       REL_SAT        = 4'd10;
    localparam logic [SFX_CNT_W-1:0]   SFX_CNT_MAX    = 4'd8;
    localparam logic [NAME_HASH_W-1:0] NAME_HASH_INIT = 30'd3000000;

    localparam logic [KEY_W-1:0] KEY_EMPTY   = 31'd999999;
    localparam logic [KEY_W-1:0] PREFIX_BASE = 31'd5000000;
    localparam logic [KEY_W-1:0] HASH_BASE   = 31'd3000000;
    localparam logic [KEY_W-1:0] NUMBER_STEP = 31'd100000;
    localparam logic [15:0]      OFF_UPPER   = 16'd10000;
    localparam logic [15:0]      OFF_MIXED   = 16'd20000;
    localparam logic [15:0]      OFF_OTHER   = 16'd30000;

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_C    = 8'h43;
    localparam logic [7:0] CHAR_UP_H    = 8'h48;
    localparam logic [7:0] CHAR_UP_M    = 8'h4D;
    localparam logic [7:0] CHAR_UP_R    = 8'h52;
    localparam logic [7:0] CHAR_UP_T    = 8'h54;
    localparam logic [7:0] CHAR_UP_X    = 8'h58;
    localparam logic [7:0] CHAR_UP_Y    = 8'h59;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_C    = 8'h63;
    localparam logic [7:0] CHAR_LO_H    = 8'h68;
    localparam logic [7:0] CHAR_LO_R    = 8'h72;
    localparam logic [7:0] CHAR_LO_Z    = 8'h7A;

    typedef enum logic [1:0] {
        PH_CHROM,
        PH_POS,
        PH_TAIL
    } t_phase;

    // Everything the key stage needs about one finished line
    typedef struct packed {
        logic [FIELD_LEN_W-1:0] field_len;
        logic                   len_zero;
        logic                   len_three;
        logic                   prefix_hit;
        logic [23:0]            first3;
        logic                   in_digits;
        logic                   digit_seen;
        logic [DIGIT_W-1:0]     digit_value;
        logic [HASH15_W-1:0]    suffix_hash;
        logic [HASH15_W-1:0]    mt_hash;
        logic [15:0]            rem_head;
        logic [REL_W-1:0]       rel_index;
        logic [NAME_HASH_W-1:0] name_hash;
        logic [POS_W-1:0]       position;
        logic                   record_valid;
    } t_line_sum;

endpackage

@@ hdl/cske_line_scan.sv @@
// Per-byte line scanner: running hashes, counters and position parse.
module cske_line_scan
    import cske_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic [7:0] i_data_byte,
    input  logic      i_line_end,
    input  logic      i_sum_ready,
    output logic      o_take,
    output logic      o_sum_valid,
    output t_line_sum o_sum
);

    function automatic logic [HASH15_W-1:0] hash15(input logic [HASH15_W-1:0] h,
                                                   input logic [7:0] b);
        return {h[HASH15_W-6:0], 5'b0} - h + {{(HASH15_W-8){1'b0}}, b};
    endfunction

    function automatic logic [NAME_HASH_W-1:0] hash30(input logic [NAME_HASH_W-1:0] h,
                                                      input logic [7:0] b);
        return {h[NAME_HASH_W-6:0], 5'b0} - h + {{(NAME_HASH_W-8){1'b0}}, b};
    endfunction

    function automatic logic prefix_match(input logic [23:0] f);
        return ((f[7:0] | 8'h20) == CHAR_LO_C) && ((f[15:8] | 8'h20) == CHAR_LO_H)
            && ((f[23:16] | 8'h20) == CHAR_LO_R);
    endfunction

    t_phase                  r_phase, n_phase;
    logic [LENGTH_BITS-1:0]  r_byte_index, u_byte_index;
    logic [23:0]             r_first3, u_first3;
    logic                    r_in_digits, u_in_digits;
    logic                    r_digit_seen, u_digit_seen;
    logic [DIGIT_W-1:0]      r_digit_value, u_digit_value;
    logic [HASH15_W-1:0]     r_suffix_hash, u_suffix_hash;
    logic [SFX_CNT_W-1:0]    r_suffix_count, u_suffix_count;
    logic [HASH15_W-1:0]     r_mt_hash, u_mt_hash;
    logic [15:0]             r_rem_head, u_rem_head;
    logic [REL_W-1:0]        r_rel_index, u_rel_index;
    logic [NAME_HASH_W-1:0]  r_name_hash, u_name_hash;
    logic [POS_W-1:0]        r_pos, u_pos;
    logic                    r_pos_ovf, u_pos_ovf;
    logic                    r_sum_valid;
    t_line_sum               r_sum, n_sum;

    logic       is_tab;
    logic       is_digit;
    logic [3:0] dval;
    logic       line_done;

    assign is_tab    = (i_data_byte == CHAR_TAB);
    assign is_digit  = (i_data_byte >= CHAR_ZERO) && (i_data_byte <= CHAR_NINE);
    assign dval      = 4'(i_data_byte - CHAR_ZERO);
    assign o_take    = i_valid && (!i_line_end || !r_sum_valid || i_sum_ready);
    assign line_done = o_take && i_line_end;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_CHROM: if (is_tab) n_phase = PH_POS;
            PH_POS:   if (!is_digit) n_phase = PH_TAIL;
            PH_TAIL:  n_phase = PH_TAIL;
            default:  n_phase = PH_CHROM;
        endcase
    end

    always_comb begin
        logic       trk_clear;
        logic [8:0] dv_next;
        logic [34:0] p10;
        trk_clear      = 1'b0;
        dv_next        = '0;
        p10            = '0;
        u_byte_index   = r_byte_index;
        u_first3       = r_first3;
        u_in_digits    = r_in_digits;
        u_digit_seen   = r_digit_seen;
        u_digit_value  = r_digit_value;
        u_suffix_hash  = r_suffix_hash;
        u_suffix_count = r_suffix_count;
        u_mt_hash      = r_mt_hash;
        u_rem_head     = r_rem_head;
        u_rel_index    = r_rel_index;
        u_name_hash    = r_name_hash;
        u_pos          = r_pos;
        u_pos_ovf      = r_pos_ovf;

        if (r_phase == PH_CHROM && !is_tab) begin
            if (r_byte_index == LENGTH_BITS'(0)) begin
                u_first3[7:0] = i_data_byte;
            end else if (r_byte_index == LENGTH_BITS'(1)) begin
                u_first3[15:8] = i_data_byte;
            end else if (r_byte_index == LENGTH_BITS'(2)) begin
                u_first3[23:16] = i_data_byte;
            end

            // a "chr" prefix restarts the name tracker on the fourth byte
            trk_clear = (r_byte_index == LENGTH_BITS'(3)) && prefix_match(r_first3);
            if (trk_clear) begin
                u_in_digits    = 1'b1;
                u_digit_seen   = 1'b0;
                u_digit_value  = '0;
                u_suffix_hash  = '0;
                u_suffix_count = '0;
                u_mt_hash      = '0;
                u_rem_head     = '0;
                u_rel_index    = '0;
            end

            if (u_rel_index == REL_W'(0)) begin
                u_rem_head = {8'h00, i_data_byte};
            end else if (u_rel_index == REL_W'(1)) begin
                u_rem_head[15:8] = i_data_byte;
            end
            if (u_rel_index >= REL_W'(2) && u_rel_index < REL_SAT) begin
                u_mt_hash = hash15(u_mt_hash, i_data_byte);
            end

            if (u_in_digits && is_digit) begin
                dv_next = {u_digit_value, 3'b0} + {3'b0, u_digit_value, 1'b0}
                        + {5'b0, dval};
                u_digit_value = (dv_next > 9'(DIGIT_SAT)) ? DIGIT_SAT : dv_next[DIGIT_W-1:0];
                u_digit_seen  = 1'b1;
            end else begin
                u_in_digits = 1'b0;
                if (u_suffix_count < SFX_CNT_MAX) begin
                    u_suffix_hash  = hash15(u_suffix_hash, i_data_byte);
                    u_suffix_count = u_suffix_count + SFX_CNT_W'(1);
                end
            end
            if (u_rel_index < REL_SAT) begin
                u_rel_index = u_rel_index + REL_W'(1);
            end

            if (r_byte_index < LENGTH_BITS'(16)) begin
                u_name_hash = hash30(r_name_hash, i_data_byte);
            end
            if (r_byte_index != '1) begin
                u_byte_index = r_byte_index + LENGTH_BITS'(1);
            end
        end

        if (r_phase == PH_POS && is_digit) begin
            p10 = {1'b0, r_pos, 3'b0} + {3'b0, r_pos, 1'b0} + {31'b0, dval};
            if (p10 > {4'b0, POS_MAX}) begin
                u_pos     = POS_MAX;
                u_pos_ovf = 1'b1;
            end else begin
                u_pos = p10[POS_W-1:0];
            end
        end
    end

    always_comb begin
        n_sum.field_len    = (33'(u_byte_index) > 33'(FIELD_LEN_MAX))
                           ? FIELD_LEN_MAX : FIELD_LEN_W'(u_byte_index);
        n_sum.len_zero     = (u_byte_index == '0);
        n_sum.len_three    = (u_byte_index == LENGTH_BITS'(3));
        n_sum.prefix_hit   = (u_byte_index >= LENGTH_BITS'(3)) && prefix_match(u_first3);
        n_sum.first3       = u_first3;
        n_sum.in_digits    = u_in_digits;
        n_sum.digit_seen   = u_digit_seen;
        n_sum.digit_value  = u_digit_value;
        n_sum.suffix_hash  = u_suffix_hash;
        n_sum.mt_hash      = u_mt_hash;
        n_sum.rem_head     = u_rem_head;
        n_sum.rel_index    = u_rel_index;
        n_sum.name_hash    = u_name_hash;
        n_sum.position     = u_pos;
        n_sum.record_valid = (n_phase != PH_CHROM) && (u_pos != '0) && !u_pos_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || line_done) begin
            r_phase        <= PH_CHROM;
            r_byte_index   <= '0;
            r_first3       <= '0;
            r_in_digits    <= 1'b1;
            r_digit_seen   <= 1'b0;
            r_digit_value  <= '0;
            r_suffix_hash  <= '0;
            r_suffix_count <= '0;
            r_mt_hash      <= '0;
            r_rem_head     <= '0;
            r_rel_index    <= '0;
            r_name_hash    <= NAME_HASH_INIT;
            r_pos          <= '0;
            r_pos_ovf      <= 1'b0;
        end else if (o_take) begin
            r_phase        <= n_phase;
            r_byte_index   <= u_byte_index;
            r_first3       <= u_first3;
            r_in_digits    <= u_in_digits;
            r_digit_seen   <= u_digit_seen;
            r_digit_value  <= u_digit_value;
            r_suffix_hash  <= u_suffix_hash;
            r_suffix_count <= u_suffix_count;
            r_mt_hash      <= u_mt_hash;
            r_rem_head     <= u_rem_head;
            r_rel_index    <= u_rel_index;
            r_name_hash    <= u_name_hash;
            r_pos          <= u_pos;
            r_pos_ovf      <= u_pos_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (line_done) begin
            r_sum_valid <= 1'b1;
        end else if (i_sum_ready) begin
            r_sum_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_done) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;

endmodule

@@ hdl/cske_key_calc.sv @@
// Natural-order key calculation and result register.
module cske_key_calc
    import cske_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_natural_order,
    input  logic                   i_sum_valid,
    input  t_line_sum              i_sum,
    output logic                   o_sum_ready,
    input  logic                   i_ready,
    output logic                   o_valid,
    output logic [KEY_W-1:0]       o_chrom_key,
    output logic [POS_W-1:0]       o_position,
    output logic [FIELD_LEN_W-1:0] o_chrom_length,
    output logic                   o_record_valid
);

    localparam logic [DIGIT_W-1:0] MAJOR_M = 5'd23;
    localparam logic [DIGIT_W-1:0] MAJOR_X = 5'd24;
    localparam logic [DIGIT_W-1:0] MAJOR_Y = 5'd25;

    function automatic logic [7:0] upper_ascii(input logic [7:0] b);
        return (b >= CHAR_LO_A && b <= CHAR_LO_Z) ? b - 8'd32 : b;
    endfunction

    logic                   r_valid;
    logic [KEY_W-1:0]       r_key;
    logic [POS_W-1:0]       r_pos;
    logic [FIELD_LEN_W-1:0] r_len;
    logic                   r_rec;
    logic [KEY_W-1:0]       n_key;
    logic                   load;

    assign o_sum_ready = !r_valid || i_ready;
    assign load        = i_sum_valid && o_sum_ready;

    always_comb begin
        logic [7:0]         c0, c1, f0, f1, f2;
        logic [15:0]        sfx, sel_sfx, off;
        logic [KEY_W-1:0]   base, fallback;
        logic [DIGIT_W-1:0] major;
        logic               use_num;
        c0       = upper_ascii(i_sum.rem_head[7:0]);
        c1       = upper_ascii(i_sum.rem_head[15:8]);
        f0       = i_sum.first3[7:0];
        f1       = i_sum.first3[15:8];
        f2       = i_sum.first3[23:16];
        sfx      = i_sum.in_digits ? 16'd0 : {1'b0, i_sum.suffix_hash} + 16'd1;
        base     = i_sum.prefix_hit ? PREFIX_BASE : '0;
        fallback = base + KEY_W'(i_sum.name_hash) + HASH_BASE;
        if (!i_sum.prefix_hit) begin
            off = '0;
        end else if (f0 == CHAR_UP_C && f1 == CHAR_UP_H && f2 == CHAR_UP_R) begin
            off = OFF_UPPER;
        end else if (f0 == CHAR_UP_C && f1 == CHAR_LO_H) begin
            off = OFF_MIXED;
        end else begin
            off = OFF_OTHER;
        end

        use_num = 1'b1;
        major   = i_sum.digit_value;
        sel_sfx = sfx;
        n_key   = '0;
        priority if (i_sum.len_zero) begin
            use_num = 1'b0;
            n_key   = KEY_EMPTY;
        end else if (!i_natural_order) begin
            use_num = 1'b0;
            n_key   = '0;
        end else if (i_sum.prefix_hit && i_sum.len_three) begin
            use_num = 1'b0;
            n_key   = KEY_EMPTY;
        end else if (i_sum.digit_seen && i_sum.digit_value >= DIGIT_W'(1)
                     && i_sum.digit_value <= NUMBER_MAX) begin
            major = i_sum.digit_value;
        end else if (!i_sum.digit_seen && i_sum.rel_index >= REL_W'(2)
                     && c0 == CHAR_UP_M && c1 == CHAR_UP_T) begin
            major = MAJOR_M;
            // anything after "MT" hashes from the third byte up to the tenth
            if (i_sum.rel_index > REL_W'(2)) begin
                sel_sfx = {1'b0, i_sum.mt_hash} + 16'd1;
            end
        end else if (!i_sum.digit_seen && i_sum.rel_index == REL_W'(1)
                     && c0 == CHAR_UP_M) begin
            major = MAJOR_M;
        end else if (!i_sum.digit_seen && i_sum.rel_index == REL_W'(1)
                     && c0 == CHAR_UP_X) begin
            major = MAJOR_X;
        end else if (!i_sum.digit_seen && i_sum.rel_index == REL_W'(1)
                     && c0 == CHAR_UP_Y) begin
            major = MAJOR_Y;
        end else begin
            use_num = 1'b0;
            n_key   = fallback;
        end
        if (use_num) begin
            n_key = base + KEY_W'(major) * NUMBER_STEP + KEY_W'(off) + KEY_W'(sel_sfx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_key <= n_key;
            r_pos <= i_sum.position;
            r_len <= i_sum.field_len;
            r_rec <= i_sum.record_valid;
        end
    end

    assign o_valid        = r_valid;
    assign o_chrom_key    = r_key;
    assign o_position     = r_pos;
    assign o_chrom_length = r_len;
    assign o_record_valid = r_rec;

endmodule

@@ hdl/chromosome_sort_key_extractor.sv @@
// Top level of the chromosome sort key extractor.
//
// Input channel: one byte of a tab-separated record line per transaction
// (i_valid / o_ready), i_line_end set on the last byte, newline excluded.
// Output channel: one transaction per line (o_valid / i_ready) carrying the
// chromosome key, the position after the first tab, the chromosome field
// length and the record valid flag. No output for bytes that do not end a line.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into natural_order
// (1 = natural chromosome key, 0 = key zero); write it only while idle.
// Throughput: one byte per cycle unless o_ready drops under a stall. Each byte passes an input
// register, the line scanner (state update, snapshot on the last byte) and
// the key calculation with its result register.
// The last byte's result passes the input register, the snapshot register
// and the result register before o_valid rises.
// Reset clears natural_order, all per-line state and every valid flag.
// When the receiver stalls, the result register holds and the snapshot
// stage behind it still takes one more finished line; bytes keep flowing
// until a second line end meets a full snapshot stage, then o_ready drops.
module chromosome_sort_key_extractor
    import cske_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_line_end,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [KEY_W-1:0]       o_chrom_key,
    output logic [POS_W-1:0]       o_position,
    output logic [FIELD_LEN_W-1:0] o_chrom_length,
    output logic                   o_record_valid
);

    logic       r_natural_order;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       scan_take;
    logic       sum_valid;
    logic       sum_ready;
    t_line_sum  sum;
    logic       accept;

    assign o_ready = !r_in_valid || scan_take;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_natural_order <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_natural_order <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (scan_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_line_end;
        end
    end

    cske_line_scan #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_data_byte (r_in_byte),
        .i_line_end  (r_in_last),
        .i_sum_ready (sum_ready),
        .o_take      (scan_take),
        .o_sum_valid (sum_valid),
        .o_sum       (sum)
    );

    cske_key_calc u_key (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_natural_order (r_natural_order),
        .i_sum_valid     (sum_valid),
        .i_sum           (sum),
        .o_sum_ready     (sum_ready),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_chrom_key     (o_chrom_key),
        .o_position      (o_position),
        .o_chrom_length  (o_chrom_length),
        .o_record_valid  (o_record_valid)
    );

endmodule

@@ tb/chromosome_sort_key_extractor_checker.sv @@
// Checker for the chromosome sort key extractor: line scanner model, result queue and compare.
module chromosome_sort_key_extractor_checker
    import cske_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_line_end,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [KEY_W-1:0]       i_chrom_key,
    input  logic [POS_W-1:0]       i_position,
    input  logic [FIELD_LEN_W-1:0] i_chrom_length,
    input  logic                   i_record_valid,
    output int unsigned            o_mismatches,
    output int unsigned            o_pending,
    output int unsigned            o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [KEY_W-1:0]       key;
        logic [POS_W-1:0]       pos;
        logic [FIELD_LEN_W-1:0] len;
        logic                   ok;
    } t_line_result;

    t_line_result awaited_results[$];

    logic        natural_mode = 1'b0;
    t_phase      scan_phase = PH_CHROM;
    int unsigned name_len, head3, num_val, num_digits, body_head, body_idx;
    int unsigned sfx_hash, sfx_cnt, mt_tail_hash, full_hash, pos_acc;
    logic        pos_ovf, body_all_digits;

    function automatic int unsigned to_upper(input int unsigned c);
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return c - 32;
        return c;
    endfunction

    function automatic logic has_chr_prefix();
        return ((head3 & 8'hFF) | 8'h20) == CHAR_LO_C &&
               (((head3 >> 8) & 8'hFF) | 8'h20) == CHAR_LO_H &&
               (((head3 >> 16) & 8'hFF) | 8'h20) == CHAR_LO_R;
    endfunction

    // state of the name after any prefix
    function automatic void restart_body();
        body_all_digits = 1'b1;
        num_val      = 0;
        num_digits   = 0;
        sfx_hash     = 0;
        sfx_cnt      = 0;
        mt_tail_hash = 0;
        body_head    = 0;
        body_idx     = 0;
    endfunction

    function automatic void restart_line();
        scan_phase = PH_CHROM;
        name_len   = 0;
        head3      = 0;
        full_hash  = NAME_HASH_INIT;
        pos_acc    = 0;
        pos_ovf    = 1'b0;
        restart_body();
    endfunction

    function automatic void scan_body_byte(input int unsigned b);
        int unsigned v;
        if (body_idx == 0) body_head = b;
        else if (body_idx == 1) body_head |= b << 8;
        if (body_idx >= 2 && body_idx < 10) mt_tail_hash = (mt_tail_hash * 31 + b) & 32'h7FFF;
        if (body_all_digits && b >= CHAR_ZERO && b <= CHAR_NINE) begin
            v = num_val * 10 + (b - CHAR_ZERO);
            num_val = (v > DIGIT_SAT) ? DIGIT_SAT : v;
            if (num_digits < 32'hFFFF) num_digits++;
        end else begin
            body_all_digits = 1'b0;
            if (sfx_cnt < 8) begin
                sfx_hash = (sfx_hash * 31 + b) & 32'h7FFF;
                sfx_cnt++;
            end
        end
        if (body_idx < 255) body_idx++;
    endfunction

    function automatic void scan_line_byte(input int unsigned b);
        longint unsigned v;
        if (scan_phase == PH_CHROM) begin
            if (b == CHAR_TAB) begin
                scan_phase = PH_POS;
                return;
            end
            if (name_len < 3) head3 |= b << (8 * name_len);
            // a full chr prefix restarts the name body on the fourth byte
            if (name_len == 3 && has_chr_prefix()) restart_body();
            scan_body_byte(b);
            if (name_len < 16) full_hash = (full_hash * 31 + b) & 32'h3FFF_FFFF;
            if (name_len < 32'hFFFF) name_len++;
        end else if (scan_phase == PH_POS) begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                v = 64'(pos_acc) * 10 + (b - CHAR_ZERO);
                if (v > POS_MAX) begin
                    pos_ovf = 1'b1;
                    v = POS_MAX;
                end
                pos_acc = 32'(v);
            end else begin
                scan_phase = PH_TAIL;
            end
        end
    endfunction

    function automatic int unsigned line_key();
        int unsigned base, off, sfx, c0, c1, b0, b1, b2;
        logic        pre;
        base = 0;
        off  = 0;
        if (name_len == 0) return KEY_EMPTY;
        if (!natural_mode) return 0;
        pre = name_len >= 3 && has_chr_prefix();
        if (pre && name_len == 3) return KEY_EMPTY;
        if (pre) begin
            b0 = head3 & 8'hFF;
            b1 = (head3 >> 8) & 8'hFF;
            b2 = (head3 >> 16) & 8'hFF;
            base = PREFIX_BASE;
            if (b0 == CHAR_UP_C && b1 == CHAR_UP_H && b2 == CHAR_UP_R) off = OFF_UPPER;
            else if (b0 == CHAR_UP_C && b1 == CHAR_LO_H) off = OFF_MIXED;
            else off = OFF_OTHER;
        end
        sfx = body_all_digits ? 0 : sfx_hash + 1;
        if (num_digits > 0 && num_val >= 1 && num_val <= NUMBER_MAX)
            return base + num_val * NUMBER_STEP + off + sfx;
        if (num_digits == 0) begin
            c0 = to_upper(body_head & 8'hFF);
            c1 = to_upper((body_head >> 8) & 8'hFF);
            if (body_idx >= 2 && c0 == CHAR_UP_M && c1 == CHAR_UP_T)
                return base + 23 * NUMBER_STEP + off + (body_idx > 2 ? mt_tail_hash + 1 : sfx);
            if (body_idx == 1) begin
                if (c0 == CHAR_UP_M) return base + 23 * NUMBER_STEP + off + sfx;
                if (c0 == CHAR_UP_X) return base + 24 * NUMBER_STEP + off + sfx;
                if (c0 == CHAR_UP_Y) return base + 25 * NUMBER_STEP + off + sfx;
            end
        end
        return base + full_hash + HASH_BASE;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        o_mismatches++;
        $display("[%0t] result %0d: %s is %0d, expected %0d", $time, o_checked, what,
                 got, want);
    endtask

    task automatic check_result();
        t_line_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch("unexpected transaction, key", i_chrom_key, 0);
            return;
        end
        want = awaited_results.pop_front();
        if (i_chrom_key !== want.key) report_mismatch("chrom_key", i_chrom_key, want.key);
        if (i_position !== want.pos) report_mismatch("position", i_position, want.pos);
        if (i_chrom_length !== want.len)
            report_mismatch("chrom_length", i_chrom_length, want.len);
        if (i_record_valid !== want.ok)
            report_mismatch("record_valid", i_record_valid, want.ok);
        o_checked++;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        t_line_result res;
        scan_line_byte(b);
        if (!last) return;
        res.key = KEY_W'(line_key());
        res.pos = POS_W'(pos_acc);
        res.len = (name_len > 32'hFFFF) ? FIELD_LEN_MAX : FIELD_LEN_W'(name_len);
        res.ok  = scan_phase != PH_CHROM && pos_acc > 0 && !pos_ovf;
        awaited_results.insert(awaited_results.size(), res);
        restart_line();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            natural_mode = 1'b0;
            restart_line();
            awaited_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_wr_en) natural_mode = i_cfg_wr_data;
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) take_byte(i_data_byte, i_line_end);
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ tb/chromosome_sort_key_extractor_test.sv @@
// Top of the chromosome sort key extractor testbench: clock, reset, line stimulus and verdict.
module chromosome_sort_key_extractor_test;
    import cske_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SETTLE      = 8;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic                   i_cfg_wr_data = 1'b0;
    logic                   i_valid       = 1'b0;
    logic [7:0]             i_data_byte   = 8'h00;
    logic                   i_line_end    = 1'b0;
    logic                   i_ready       = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic [KEY_W-1:0]       o_chrom_key;
    logic [POS_W-1:0]       o_position;
    logic [FIELD_LEN_W-1:0] o_chrom_length;
    logic                   o_record_valid;

    int unsigned mismatches, pending, checked;
    int unsigned cycles     = 0;
    int unsigned bytes_sent = 0;
    int unsigned lines_sent = 0;
    logic        steady     = 1'b0;
    logic [7:0]  line_buf[$];

    chromosome_sort_key_extractor DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_line_end     (i_line_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chrom_key    (o_chrom_key),
        .o_position     (o_position),
        .o_chrom_length (o_chrom_length),
        .o_record_valid (o_record_valid)
    );

    chromosome_sort_key_extractor_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_data_byte    (i_data_byte),
        .i_line_end     (i_line_end),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_chrom_key    (o_chrom_key),
        .i_position     (o_position),
        .i_chrom_length (o_chrom_length),
        .i_record_valid (o_record_valid),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!steady && $urandom_range(99) < 15) i_ready <= 1'b0;
        else i_ready <= 1'b1;
    end

    task automatic add_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    function automatic logic [7:0] any_case(input logic [7:0] up);
        return $urandom_range(1) ? up : (up | 8'h20);
    endfunction

    function automatic logic [7:0] rand_letter();
        return any_case(8'($urandom_range(CHAR_UP_C - 2, CHAR_UP_C + 23)));
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_line_end  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int k = 0; k < line_buf.size(); k++) send_byte(line_buf[k], k == line_buf.size() - 1);
        line_buf.delete();
        lines_sent++;
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_line();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_wr_data <= mode;
        i_cfg_wr_en   <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        send_text("\t5");                  // empty name
        send_text("\t");                   // empty name, line ends on the tab
        send_text("chr\t10");              // bare prefix
        send_text("chr1\t100");
        send_text("CHR22\t2147483647");    // largest position
        send_text("Chr23\t1");
        send_text("cHrX\t9");
        send_text("chrm\t1");
        send_text("chrMT\t1");
        send_text("CHRmTabc\t1");
        send_text("mt\t5");
        send_text("Y\t0");                 // zero position
        send_text("x");                    // no tab at all
        send_text("007\t12abc\tq");        // leading zeros, trailing bytes
        send_text("1abc\t3");
        send_text("scaffold_12345678901\t2147483648");  // long name, position overflow
        send_text("chrUn_gl000220\t44");
        send_text("0\t1");
        send_text("22\t99999999999");
        send_text("chrYz\t8");
        send_text("abcdefghijklmnopqrstuvw");
        add_byte(8'hFF);
        add_byte(8'h00);
        put_text("\t1");
        send_line();
    endtask

    task automatic build_random_line();
        int unsigned pick, n;
        logic [7:0]  b;
        if ($urandom_range(99) < 12) begin
            // noise: any bytes, tabs included
            n = $urandom_range(1, 20);
            repeat (n) add_byte(8'($urandom()));
            return;
        end
        pick = $urandom_range(9);
        if (pick == 4) put_text("chr");
        else if (pick == 5) put_text("CHR");
        else if (pick == 6) put_text("Chr");
        else if (pick >= 7) begin
            add_byte(any_case(CHAR_UP_C));
            add_byte(any_case(CHAR_UP_H));
            add_byte(any_case(CHAR_UP_R));
        end
        pick = $urandom_range(11);
        case (pick)
            0, 1: begin
                repeat ($urandom_range(2)) put_text("0");
                put_text($sformatf("%0d", $urandom_range(1, 22)));
                if (pick == 1) repeat ($urandom_range(1, 10)) add_byte(rand_letter());
            end
            2: begin
                n = $urandom_range(3);
                if (n == 0) put_text("0");
                else if (n == 1) put_text($sformatf("%0d", $urandom_range(23, 999)));
                else put_text($sformatf("%0d", $urandom()));
            end
            3: add_byte(any_case(CHAR_UP_M));
            4, 5: begin
                add_byte(any_case(CHAR_UP_M));
                add_byte(any_case(CHAR_UP_T));
                if (pick == 5) begin
                    repeat ($urandom_range(1, 12)) begin
                        if ($urandom_range(3) == 0)
                            add_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
                        else add_byte(rand_letter());
                    end
                end
            end
            6: add_byte(any_case(CHAR_UP_X));
            7: add_byte(any_case(CHAR_UP_Y));
            8: begin
                n = $urandom_range(2);
                add_byte(any_case(n == 0 ? CHAR_UP_M : (n == 1 ? CHAR_UP_X : CHAR_UP_Y)));
                repeat ($urandom_range(1, 4)) add_byte(rand_letter());
            end
            9: begin
                repeat ($urandom_range(1, 24)) begin
                    if ($urandom_range(2) == 0)
                        add_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
                    else add_byte(rand_letter());
                end
            end
            10: begin
                repeat ($urandom_range(1, 20)) begin
                    do b = 8'($urandom()); while (b == CHAR_TAB);
                    add_byte(b);
                end
            end
            default: ;  // empty name, or a bare prefix
        endcase
        if ($urandom_range(99) < 8) begin
            if (line_buf.size() == 0) add_byte(rand_letter());
            return;
        end
        add_byte(CHAR_TAB);
        pick = $urandom_range(9);
        if (pick == 1) put_text("0");
        else if (pick == 2) put_text("2147483647");
        else if (pick == 3) begin
            put_text($sformatf("%0d", $urandom_range(3, 9)));
            repeat ($urandom_range(9, 12))
                add_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        end else if (pick != 0) put_text($sformatf("%0d", $urandom_range(1, 999999999)));
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom()));
    endtask

    initial begin
        logic        modes[6];
        int unsigned phase_start;
        modes = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();           // natural_order still at its reset value
        drain();
        write_mode(1'b1);
        run_directed();
        drain();

        for (int p = 0; p < 6; p++) begin
            write_mode(modes[p]);
            steady = (p == 2);    // whole phase without gaps or stalls
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 90) begin
                build_random_line();
                send_line();
            end
            drain();
        end
        steady = 1'b0;

        $display("Sent %0d lines (%0d bytes) over both key modes; %0d results compared.",
                 lines_sent, bytes_sent, checked);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
